// File: src/dvfe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the delta varint field encoder.
// No dependencies; imported by the encoder top level and its checker.

package dvfe_pkg;

  // Per-column timestamp store; column numbers wrap onto the store by
  // their low bits, so the depth is a power of two.
  localparam int unsigned NumColumns = 16;
  localparam int unsigned ColW       = $clog2(NumColumns);

  // Input word fields
  localparam int unsigned FuncW   = 1;
  localparam int unsigned ColumnW = 4;
  localparam int unsigned ValueW  = 64;

  // tdata carries {value, column}, padded to whole bytes
  localparam int unsigned InFieldsW = ColumnW + ValueW;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned InTuserW  = FuncW;

  localparam int unsigned OutTdataW = 8;

  // LEB128 group layout
  localparam int unsigned        GroupW    = 7;
  localparam logic [GroupW-1:0]  GroupMask = 7'h7F;
  localparam logic [7:0]         MoreFlag  = 8'h80;

  // Raw timestamp goes out as this many little-endian bytes
  localparam int unsigned RawBytes = ValueW / 8;
  localparam int unsigned RawCntW  = $clog2(RawBytes);

  // Operation selector carried in tuser
  typedef enum logic [FuncW-1:0] {
    FUNC_VARINT = 1'b0,
    FUNC_TSTAMP = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_EMIT   = 3'b100
  } state_e;

endpackage

// File: src/delta_varint_field_encoder.sv
`timescale 1ns / 1ps
// Delta varint field encoder top level: one input word in, 1..10 bytes out.
// Depends on dvfe_pkg.
//
// Usage:
//   Slave stream (s_axis_*) takes one word per item: tuser is the operation
//   (varint of value, or timestamp delta), tdata holds column and value.
//   Master stream (m_axis_*) returns the encoded bytes one per word, tlast
//   marking the final byte of the item.
//   Plain varint: value goes out as LEB128, 1..10 bytes.
//   Timestamp: the column's previous timestamp is read from a 16-entry
//   synchronous store. Zero previous -> 8 raw little-endian bytes, else the
//   LEB128 of the wrapped difference. The value is written back as the new
//   previous timestamp.
// Item flow:
//   One item at a time. The first byte is offered in the cycle after acceptance
//   for a plain varint; a timestamp first passes S_LOOKUP for the store read.
//   Bytes then leave one per cycle while the receiver takes them. A new word
//   is taken once tlast has gone out.
// Reset:
//   Clears the state machine and the per-column valid bits, so every column
//   reads as a zero timestamp. No clearing pass is needed.
// Stalls:
//   While m_axis_tready is low the current byte holds on the output and the
//   input side stays not ready.

module delta_varint_field_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [3:0] column, [67:4] value, [71:68] zero
  input  logic [dvfe_pkg::InTdataW-1:0]  s_axis_tdata,
  // tuser: [0] func
  input  logic [dvfe_pkg::InTuserW-1:0]  s_axis_tuser,
  // master stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [7:0] out_byte
  output logic [dvfe_pkg::OutTdataW-1:0] m_axis_tdata,
  // tlast: last byte of the item
  output logic                           m_axis_tlast
);
  import dvfe_pkg::*;

  state_e state_q, state_d;

  // item registers
  logic [ValueW-1:0]  value_q;
  logic [ColW-1:0]    idx_q;
  logic [ValueW-1:0]  sh_q, sh_d;     // bytes still to send, low first
  logic               raw_q, raw_d;   // raw 8-byte mode
  logic [RawCntW-1:0] cnt_q, cnt_d;   // raw byte count

  // timestamp store: memory plus a valid bit per entry
  logic [ValueW-1:0]     mem_q [NumColumns];
  logic [ValueW-1:0]     rd_q;
  logic [NumColumns-1:0] valid_q;
  logic                  rd_en;
  logic                  wr_en;

  logic               in_acc;
  logic               out_acc;
  logic [ColumnW-1:0] in_column;
  logic [ValueW-1:0]  in_value;
  func_e              in_func;
  logic [ValueW-1:0]  prev;
  logic               more;
  logic               last_byte;

  assign in_column = s_axis_tdata[ColumnW-1:0];
  assign in_value  = s_axis_tdata[ColumnW +: ValueW];
  assign in_func   = func_e'(s_axis_tuser[0]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // Never-written columns read as zero
  assign prev = valid_q[idx_q] ? rd_q : '0;

  // Output byte straight from the shift register
  assign more      = |sh_q[ValueW-1:GroupW];
  assign last_byte = raw_q ? (cnt_q == RawCntW'(RawBytes - 1)) : !more;
  assign m_axis_tdata = raw_q ? sh_q[7:0] : ({1'b0, sh_q[GroupW-1:0] & GroupMask} |
                                             (more ? MoreFlag : 8'h00));
  assign m_axis_tlast = last_byte;

  assign rd_en = in_acc && (in_func == FUNC_TSTAMP);
  assign wr_en = (state_q == S_LOOKUP);

  always_comb begin
    state_d = state_q;
    sh_d    = sh_q;
    raw_d   = raw_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sh_d  = in_value;
          raw_d = 1'b0;
          cnt_d = '0;
          state_d = (in_func == FUNC_TSTAMP) ? S_LOOKUP : S_EMIT;
        end
      end
      S_LOOKUP: begin
        // read data is back; choose raw or delta, store writes back now
        raw_d   = (prev == '0);
        sh_d    = (prev == '0) ? value_q : value_q - prev;
        cnt_d   = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          sh_d  = raw_q ? {8'h00, sh_q[ValueW-1:8]} : {{GroupW{1'b0}}, sh_q[ValueW-1:GroupW]};
          cnt_d = cnt_q + 1'b1;
          if (last_byte) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    raw_q <= raw_d;
    cnt_q <= cnt_d;
    if (in_acc) begin
      value_q <= in_value;
      idx_q   <= in_column[ColW-1:0];
    end
  end

  // Store: one read, one write port; accesses never overlap since the
  // write-back finishes before the next word is taken.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[in_column[ColW-1:0]];
    end
    if (wr_en) begin
      mem_q[idx_q] <= value_q;
    end
  end

endmodule

// File: src/dvfe_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the delta varint field encoder, bound to the top.
// Depends on dvfe_pkg.

module dvfe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [dvfe_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic [dvfe_pkg::InTuserW-1:0]  s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dvfe_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import dvfe_pkg::*;

  // one item at a time: never ready while a byte is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output word pending");

  // a taken word closes the input side for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after accept");

  // final byte taken: output goes quiet and input reopens
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
    else $error("item did not end after tlast");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

endmodule

bind delta_varint_field_encoder dvfe_checker u_dvfe_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for delta_varint_field_encoder: directed and random words
// in, every encoded byte checked against a local predictor, random stalls.
// Depends on dvfe_pkg and the encoder RTL.

module tb_top;
  import dvfe_pkg::*;

  localparam int unsigned ClkHalf     = 2;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned RandWords   = 420;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [OutTdataW-1:0] data;
    logic                 last;
  } enc_byte_t;

  // Predicts the byte stream for each accepted word and checks the output.
  class encoded_byte_board;
    enc_byte_t         exp_bytes[$];
    logic [ValueW-1:0] prev_stamp[NumColumns];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       plain_cnt;
    int unsigned       raw_cnt;
    int unsigned       delta_cnt;

    function new();
      foreach (prev_stamp[i]) prev_stamp[i] = '0;
      mismatches = 0;
      checked    = 0;
      plain_cnt  = 0;
      raw_cnt    = 0;
      delta_cnt  = 0;
    endfunction

    // append one expected byte at the tail of the queue
    function void add_byte(logic [OutTdataW-1:0] d, logic l);
      enc_byte_t b;
      b.data = d;
      b.last = l;
      exp_bytes.insert(exp_bytes.size(), b);
    endfunction

    // LEB128: low group first, continuation flag on all but the final byte
    function void push_varint(logic [ValueW-1:0] v);
      while (v >= ValueW'(MoreFlag)) begin
        add_byte(MoreFlag | {1'b0, v[GroupW-1:0]}, 1'b0);
        v = v >> GroupW;
      end
      add_byte({1'b0, v[GroupW-1:0]}, 1'b1);
    endfunction

    function void push_raw(logic [ValueW-1:0] v);
      for (int i = 0; i < RawBytes; i++) begin
        add_byte(v[8*i +: 8], (i == RawBytes - 1));
      end
    endfunction

    function void note_word(func_e op, logic [ColumnW-1:0] col, logic [ValueW-1:0] v);
      int unsigned slot;
      slot = col % NumColumns;
      if (op == FUNC_VARINT) begin
        push_varint(v);
        plain_cnt++;
      end else begin
        if (prev_stamp[slot] == '0) begin
          push_raw(v);
          raw_cnt++;
        end else begin
          push_varint(v - prev_stamp[slot]);  // wraps mod 2^64
          delta_cnt++;
        end
        prev_stamp[slot] = v;
      end
    endfunction

    function void check_byte(logic [OutTdataW-1:0] data, logic last);
      enc_byte_t want;
      checked++;
      if (exp_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("ERROR @%0t: byte %02h last %0b arrived with nothing expected",
                   $time, data, last);
      end else begin
        want = exp_bytes.pop_front();
        if (want.data !== data || want.last !== last) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("ERROR @%0t: byte #%0d expected %02h last %0b, got %02h last %0b",
                     $time, checked, want.data, want.last, data, last);
        end
      end
    endfunction

    function int unsigned pending();
      return exp_bytes.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [InTuserW-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  encoded_byte_board board;
  bit                gaps_en    = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       cycle_cnt  = 0;

  delta_varint_field_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word, wait for the handshake, then maybe idle. tvalid stays
  // high across back-to-back words.
  task automatic send_word(func_e op, logic [ColumnW-1:0] col, logic [ValueW-1:0] v);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InTdataW'({v, col});
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(op, col, v);
    gap = gaps_en ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output side: check each taken byte, stall tready at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_byte(m_axis_tdata, m_axis_tlast);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if (gaps_en) stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("delta_varint_field_encoder test failed");
      $finish;
    end
  end

  initial begin
    logic [ValueW-1:0]  last_stamp[NumColumns];
    logic [ValueW-1:0]  v;
    logic [ColumnW-1:0] col;
    func_e              op;
    int unsigned        width;
    int unsigned        r;

    board = new();
    foreach (last_stamp[i]) last_stamp[i] = ValueW'(1_600_000_000 + $urandom_range(0, 99_999));
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Varint length boundaries and bit patterns
    send_word(FUNC_VARINT, 4'd0,  64'd0);
    send_word(FUNC_VARINT, 4'd5,  64'd127);
    send_word(FUNC_VARINT, 4'd9,  64'd128);
    send_word(FUNC_VARINT, 4'd2,  64'h3FFF);
    send_word(FUNC_VARINT, 4'd2,  64'h4000);
    send_word(FUNC_VARINT, 4'd15, '1);
    send_word(FUNC_VARINT, 4'd1,  64'h8000_0000_0000_0000);
    send_word(FUNC_VARINT, 4'd3,  64'h7FFF_FFFF_FFFF_FFFF);
    send_word(FUNC_VARINT, 4'd3,  64'hAAAA_AAAA_AAAA_AAAA);
    send_word(FUNC_VARINT, 4'd3,  64'h5555_5555_5555_5555);
    // Column 3 store untouched by the varints above: first stamp goes raw
    send_word(FUNC_TSTAMP, 4'd3,  64'd1_700_000_000);
    send_word(FUNC_TSTAMP, 4'd3,  64'd1_700_000_060);   // small forward delta
    send_word(FUNC_TSTAMP, 4'd3,  64'd1_699_999_000);   // backward, 10 bytes
    send_word(FUNC_TSTAMP, 4'd3,  64'd0);               // stores a zero stamp
    send_word(FUNC_TSTAMP, 4'd3,  64'd1_700_000_000);   // raw again
    send_word(FUNC_TSTAMP, 4'd15, '1);
    send_word(FUNC_TSTAMP, 4'd15, '1);                  // zero delta
    send_word(FUNC_TSTAMP, 4'd15, 64'd0);               // delta wraps to 1
    send_word(FUNC_TSTAMP, 4'd0,  64'h0123_4567_89AB_CDEF);
    send_word(FUNC_TSTAMP, 4'd0,  64'hFEDC_BA98_7654_3210);

    // Random part: mostly plausible timestamp sequences per column,
    // mixed with plain varints of every length and some odd stamps.
    for (int n = 0; n < RandWords; n++) begin
      if (n % 60 == 0) gaps_en = ($urandom_range(0, 3) != 0);
      if (n == RandWords / 2) begin
        // hold off until the encoder has emptied out
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (board.pending() != 0);
      end
      col = ColumnW'($urandom_range(0, NumColumns - 1));
      if ($urandom_range(0, 2) == 0) begin
        op    = FUNC_VARINT;
        width = $urandom_range(0, ValueW);
        v     = {$urandom, $urandom};
        if (width < ValueW) v = v & ((64'd1 << width) - 1);
      end else begin
        op = FUNC_TSTAMP;
        r  = $urandom_range(0, 99);
        if (r < 65)      v = last_stamp[col] + $urandom_range(0, 3600);
        else if (r < 75) v = last_stamp[col] - $urandom_range(1, 600);
        else if (r < 80) v = '0;
        else if (r < 90) v = 64'd1_500_000_000 + $urandom;
        else             v = {$urandom, $urandom};
        last_stamp[col] = v;
      end
      send_word(op, col, v);
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d words: %0d plain varint, %0d raw stamp, %0d delta stamp",
             board.plain_cnt + board.raw_cnt + board.delta_cnt,
             board.plain_cnt, board.raw_cnt, board.delta_cnt);
    $display("Checked %0d output bytes, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("delta_varint_field_encoder test passed");
    end else begin
      $display("delta_varint_field_encoder test failed");
    end
    $finish;
  end

endmodule
